@@ hdl/iee_pkg.sv @@
`default_nettype none
package iee_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int ACC_W           = 60;
   localparam int DIV_W           = 128;
   localparam int DIV_STEPS       = 128;
   localparam int MUL_STEPS       = 4;
   localparam int MAX_FRAC_DIGITS = 18;

   localparam logic [ACC_W-1:0] MANT_LIMIT = ACC_W'(64'd999999999999999999);
   localparam logic [ACC_W-1:0] MANT_DIV10 = ACC_W'(64'd99999999999999999);
   localparam logic [63:0]      SMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]      SMIN       = 64'h8000_0000_0000_0000;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      OP_LPAR  = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_MUL   = 3'd3,
      OP_DIV   = 3'd4,
      OP_OTHER = 3'd5
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DIV0  = 2'd1,
      ST_UNDER = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_OP_READ, S_OP_CHECK, S_PUSH_OP, S_END,
      S_NUM_START, S_DIV_RUN, S_NUM_RND, S_DIV_FIN, S_POP_B, S_POP_A,
      S_EXEC, S_MUL_RUN, S_MUL_FIN, S_PUSH, S_OUT_RD, S_OUT_CAP
   } state_type;

   typedef enum logic [2:0] {
      M_NUM_CHAR, M_NUM_LAST, M_CLOSE, M_OPER, M_DRAIN
   } mode_type;

   typedef struct packed {
      logic stop;
      logic dot;
      logic in_num;
   } num_flags_type;

   function automatic logic [63:0] pow10(input logic [4:0] n);
      logic [63:0] p;
      unique case (n)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         default: p = 64'd1000000000000000000;
      endcase
      return p;
   endfunction

   function automatic op_code_type op_of(input logic [7:0] c);
      op_code_type o;
      unique case (c)
         CH_PLUS:  o = OP_ADD;
         CH_MINUS: o = OP_SUB;
         CH_STAR:  o = OP_MUL;
         CH_SLASH: o = OP_DIV;
         default:  o = OP_OTHER;
      endcase
      return o;
   endfunction

   function automatic logic [1:0] prio(input op_code_type o);
      logic [1:0] p;
      unique case (o)
         OP_ADD, OP_SUB: p = 2'd1;
         OP_MUL, OP_DIV: p = 2'd2;
         default:        p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_num_char(input logic [7:0] c);
      return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
   endfunction

   function automatic logic [63:0] magnitude(input logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

endpackage
`default_nettype wire

@@ hdl/iee_if.sv @@
`default_nettype none
interface iee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface iee_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [63:0]  value;
   iee_pkg::status_type status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

@@ hdl/infix_expression_evaluator.sv @@
// Digit and dot requests are taken in the idle state; other characters dispatch, then run each reduction.
// Reduction: * runs the multiplier and / the divider (one divider bit a cycle).
// Ending a number runs the shared divider; the result is read from the value stack after the final drain.
// Divides use the shared restoring divider, products a 32x32 multiplier; one request at a time.
// Reset (synchronous, active high) empties both stacks, clears number state and status.
`default_nettype none
module infix_expression_evaluator #(
   parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   iee_req_if.sink  req,
   iee_rsp_if.source rsp
);
   import iee_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int DC_W  = $clog2(DIV_STEPS);

   state_type     state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [7:0]    c_ff, c_in;
   logic          last_ff, last_in;
   logic [CNT_W-1:0] vcnt_ff, vcnt_in, ocnt_ff, ocnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [4:0]    fd_ff, fd_in;
   num_flags_type nf_ff, nf_in;
   status_type    err_ff, err_in;

   logic [64:0]      div_rem_ff, div_rem_in;
   logic [DIV_W-1:0] div_num_ff, div_num_in;
   logic [63:0]      div_q_ff, div_q_in, div_den_ff, div_den_in;
   logic             div_big_ff, div_big_in;
   logic [DC_W-1:0]  div_cnt_ff, div_cnt_in;

   logic [63:0]  mx_ff, mx_in, my_ff, my_in, mprod_ff, mprod_in;
   logic [6:0]   msh_ff, msh_in;
   logic [127:0] macc_ff, macc_in;
   logic [2:0]   mcnt_ff, mcnt_in;
   logic         neg_ff, neg_in;

   logic [63:0] b_ff, b_in, res_ff, res_in;
   logic        b_mem_ff, b_mem_in, a_mem_ff, a_mem_in;

   logic [63:0] out_value_ff, out_value_in;
   status_type  out_status_ff, out_status_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [63:0] vmem [STACK_DEPTH];
   op_code_type omem [STACK_DEPTH];
   logic [63:0] v_rd_ff;
   op_code_type o_rd_ff;
   logic          v_we, v_re, o_we, o_re;
   logic [AW-1:0] v_waddr, v_raddr, o_waddr, o_raddr;
   logic [63:0]   v_wdata;
   op_code_type   o_wdata;

   num_flags_type    nc_flags;
   logic [ACC_W-1:0] nc_acc, acc10;
   logic [4:0]       nc_fd;
   logic [3:0]       digit;
   logic             fits;
   logic [64:0]      r_sh, sf;
   logic [63:0]      a_val, sum, mag;
   logic             rnd;

   function automatic logic [64:0] sat_sign(input logic [63:0] m, input logic n);
      logic [64:0] r;
      if (n) begin
         if (m > SMIN) r = {1'b1, SMIN};
         else          r = {1'b0, ~m + 64'd1};
      end else begin
         if (m[63]) r = {1'b1, SMAX};
         else       r = {1'b0, m};
      end
      return r;
   endfunction

   assign nc_flags = nf_ff.in_num ? nf_ff : '{stop: 1'b0, dot: 1'b0, in_num: 1'b1};
   assign nc_acc   = nf_ff.in_num ? acc_ff : '0;
   assign nc_fd    = nf_ff.in_num ? fd_ff : '0;
   assign digit    = 4'(req.char_code - CH_ZERO);
   assign fits     = nc_acc <= MANT_DIV10;
   assign acc10    = (nc_acc << 3) + (nc_acc << 1) + ACC_W'(digit);
   assign r_sh     = {div_rem_ff[63:0], div_num_ff[DIV_W-1]};

   assign req.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.value  = out_value_ff;
   assign rsp.status = out_status_ff;

   always_ff @(posedge clock) begin
      if (v_we) vmem[v_waddr] <= v_wdata;
      if (v_re) v_rd_ff <= vmem[v_raddr];
      if (o_we) omem[o_waddr] <= o_wdata;
      if (o_re) o_rd_ff <= omem[o_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_DRAIN;
         vcnt_ff      <= '0;
         ocnt_ff      <= '0;
         acc_ff       <= '0;
         fd_ff        <= '0;
         nf_ff        <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         vcnt_ff      <= vcnt_in;
         ocnt_ff      <= ocnt_in;
         acc_ff       <= acc_in;
         fd_ff        <= fd_in;
         nf_ff        <= nf_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff          <= c_in;
      last_ff       <= last_in;
      div_rem_ff    <= div_rem_in;
      div_num_ff    <= div_num_in;
      div_q_ff      <= div_q_in;
      div_den_ff    <= div_den_in;
      div_big_ff    <= div_big_in;
      div_cnt_ff    <= div_cnt_in;
      mx_ff         <= mx_in;
      my_ff         <= my_in;
      mprod_ff      <= mprod_in;
      msh_ff        <= msh_in;
      macc_ff       <= macc_in;
      mcnt_ff       <= mcnt_in;
      neg_ff        <= neg_in;
      b_ff          <= b_in;
      res_ff        <= res_in;
      b_mem_ff      <= b_mem_in;
      a_mem_ff      <= a_mem_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      c_in          = c_ff;
      last_in       = last_ff;
      vcnt_in       = vcnt_ff;
      ocnt_in       = ocnt_ff;
      acc_in        = acc_ff;
      fd_in         = fd_ff;
      nf_in         = nf_ff;
      err_in        = err_ff;
      div_rem_in    = div_rem_ff;
      div_num_in    = div_num_ff;
      div_q_in      = div_q_ff;
      div_den_in    = div_den_ff;
      div_big_in    = div_big_ff;
      div_cnt_in    = div_cnt_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      mprod_in      = mprod_ff;
      msh_in        = msh_ff;
      macc_in       = macc_ff;
      mcnt_in       = mcnt_ff;
      neg_in        = neg_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      b_mem_in      = b_mem_ff;
      a_mem_in      = a_mem_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      v_we = 1'b0; v_re = 1'b0; o_we = 1'b0; o_re = 1'b0;
      v_waddr = AW'(vcnt_ff);
      v_raddr = AW'(vcnt_ff - 1'b1);
      o_waddr = AW'(ocnt_ff);
      o_raddr = AW'(ocnt_ff - 1'b1);
      v_wdata = res_ff;
      o_wdata = (c_ff == CH_LPAR) ? OP_LPAR : op_of(c_ff);
      a_val   = a_mem_ff ? v_rd_ff : '0;
      sum     = '0;
      mag     = '0;
      sf      = '0;
      rnd     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               c_in    = req.char_code;
               last_in = req.last;
               if (is_num_char(req.char_code)) begin
                  nf_in  = nc_flags;
                  acc_in = nc_acc;
                  fd_in  = nc_fd;
                  if (!nc_flags.stop) begin
                     if (req.char_code == CH_DOT) begin
                        if (nc_flags.dot) nf_in.stop = 1'b1;
                        else              nf_in.dot  = 1'b1;
                     end else if (nc_flags.dot) begin
                        if ((nc_fd < 5'(MAX_FRAC_DIGITS)) && fits) begin
                           acc_in = acc10;
                           fd_in  = nc_fd + 5'd1;
                        end
                     end else if (!fits) begin
                        if (err_ff == ST_OK) err_in = ST_OVER;
                        acc_in = MANT_LIMIT;
                     end else begin
                        acc_in = acc10;
                     end
                  end
                  state_in = req.last ? S_END : S_IDLE;
               end else if (nf_ff.in_num) begin
                  mode_in  = M_NUM_CHAR;
                  state_in = S_NUM_START;
               end else begin
                  state_in = S_DISPATCH;
               end
            end
         end
         S_DISPATCH: begin
            priority if (c_ff == CH_LPAR) begin
               state_in = S_PUSH_OP;
            end else if (c_ff == CH_RPAR) begin
               mode_in  = M_CLOSE;
               state_in = S_OP_READ;
            end else if (c_ff == CH_SPACE) begin
               state_in = S_END;
            end else begin
               mode_in  = M_OPER;
               state_in = S_OP_READ;
            end
         end
         S_OP_READ: begin
            if (ocnt_ff == '0) begin
               unique case (mode_ff)
                  M_OPER:  state_in = S_PUSH_OP;
                  M_DRAIN: state_in = S_OUT_RD;
                  default: state_in = S_END;
               endcase
            end else begin
               o_re     = 1'b1;
               state_in = S_OP_CHECK;
            end
         end
         S_OP_CHECK: begin
            priority if ((mode_ff == M_CLOSE) && (o_rd_ff == OP_LPAR)) begin
               ocnt_in  = ocnt_ff - 1'b1;
               state_in = S_END;
            end else if ((mode_ff == M_OPER) && (prio(o_rd_ff) < prio(op_of(c_ff)))) begin
               state_in = S_PUSH_OP;
            end else begin
               state_in = S_POP_B;
            end
         end
         S_PUSH_OP: begin
            if (ocnt_ff >= CNT_W'(STACK_DEPTH)) begin
               if (err_ff == ST_OK) err_in = ST_OVER;
            end else begin
               o_we    = 1'b1;
               ocnt_in = ocnt_ff + 1'b1;
            end
            state_in = S_END;
         end
         S_END: begin
            if (last_ff) begin
               if (nf_ff.in_num) begin
                  mode_in  = M_NUM_LAST;
                  state_in = S_NUM_START;
               end else begin
                  mode_in  = M_DRAIN;
                  state_in = S_OP_READ;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_NUM_START: begin
            div_num_in = {(DIV_W - ACC_W)'(0), acc_ff} << FRAC_BITS;
            div_den_in = pow10(fd_ff);
            div_rem_in = '0;
            div_q_in   = '0;
            div_big_in = 1'b0;
            div_cnt_in = '0;
            acc_in     = '0;
            fd_in      = '0;
            nf_in      = '0;
            state_in   = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            div_big_in = div_big_ff | div_q_ff[63];
            div_num_in = div_num_ff << 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (r_sh >= {1'b0, div_den_ff}) begin
               div_rem_in = r_sh - {1'b0, div_den_ff};
               div_q_in   = {div_q_ff[62:0], 1'b1};
            end else begin
               div_rem_in = r_sh;
               div_q_in   = {div_q_ff[62:0], 1'b0};
            end
            if (div_cnt_ff == DC_W'(DIV_STEPS - 1)) begin
               state_in = ((mode_ff == M_NUM_CHAR) || (mode_ff == M_NUM_LAST)) ?
                          S_NUM_RND : S_DIV_FIN;
            end
         end
         S_NUM_RND: begin
            rnd = {div_rem_ff[63:0], 1'b0} >= {1'b0, div_den_ff};
            if (div_big_ff || div_q_ff[63] || (rnd && (div_q_ff == SMAX))) begin
               if (err_ff == ST_OK) err_in = ST_OVER;
               res_in = SMAX;
            end else begin
               res_in = div_q_ff + 64'(rnd);
            end
            state_in = S_PUSH;
         end
         S_DIV_FIN: begin
            mag = div_big_ff ? '1 : div_q_ff;
            sf  = sat_sign(mag, neg_ff);
            if (sf[64] && (err_ff == ST_OK)) err_in = ST_OVER;
            res_in   = sf[63:0];
            state_in = S_PUSH;
         end
         S_POP_B: begin
            if (vcnt_ff == '0) begin
               if (err_ff == ST_OK) err_in = ST_UNDER;
               b_mem_in = 1'b0;
            end else begin
               v_re     = 1'b1;
               vcnt_in  = vcnt_ff - 1'b1;
               b_mem_in = 1'b1;
            end
            state_in = S_POP_A;
         end
         S_POP_A: begin
            b_in = b_mem_ff ? v_rd_ff : '0;
            if (vcnt_ff == '0) begin
               if (err_ff == ST_OK) err_in = ST_UNDER;
               a_mem_in = 1'b0;
            end else begin
               v_re     = 1'b1;
               vcnt_in  = vcnt_ff - 1'b1;
               a_mem_in = 1'b1;
            end
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ocnt_in = ocnt_ff - 1'b1;
            neg_in  = a_val[63] ^ b_ff[63];
            unique case (o_rd_ff)
               OP_ADD: begin
                  sum = a_val + b_ff;
                  if (((a_val ^ sum) & (b_ff ^ sum)) >> 63 != 64'd0) begin
                     if (err_ff == ST_OK) err_in = ST_OVER;
                     res_in = a_val[63] ? SMIN : SMAX;
                  end else begin
                     res_in = sum;
                  end
                  state_in = S_PUSH;
               end
               OP_SUB: begin
                  sum = a_val - b_ff;
                  if (((a_val ^ b_ff) & (a_val ^ sum)) >> 63 != 64'd0) begin
                     if (err_ff == ST_OK) err_in = ST_OVER;
                     res_in = a_val[63] ? SMIN : SMAX;
                  end else begin
                     res_in = sum;
                  end
                  state_in = S_PUSH;
               end
               OP_MUL: begin
                  mx_in    = magnitude(a_val);
                  my_in    = magnitude(b_ff);
                  macc_in  = '0;
                  mcnt_in  = '0;
                  state_in = S_MUL_RUN;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     if (err_ff == ST_OK) err_in = ST_DIV0;
                     res_in   = '0;
                     state_in = S_PUSH;
                  end else begin
                     div_num_in = {64'd0, magnitude(a_val)} << FRAC_BITS;
                     div_den_in = magnitude(b_ff);
                     div_rem_in = '0;
                     div_q_in   = '0;
                     div_big_in = 1'b0;
                     div_cnt_in = '0;
                     state_in   = S_DIV_RUN;
                  end
               end
               default: begin
                  res_in   = '0;
                  state_in = S_PUSH;
               end
            endcase
         end
         S_MUL_RUN: begin
            if (mcnt_ff < 3'(MUL_STEPS)) begin
               mprod_in = (mcnt_ff[1] ? mx_ff[63:32] : mx_ff[31:0]) *
                          (mcnt_ff[0] ? my_ff[63:32] : my_ff[31:0]);
               msh_in   = {mcnt_ff[1] & mcnt_ff[0], mcnt_ff[1] ^ mcnt_ff[0], 5'd0};
            end
            if (mcnt_ff != '0) begin
               macc_in = macc_ff + ({64'd0, mprod_ff} << msh_ff);
            end
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'(MUL_STEPS)) state_in = S_MUL_FIN;
         end
         S_MUL_FIN: begin
            mag = (macc_ff[127:64+FRAC_BITS] != '0) ? '1 : macc_ff[63+FRAC_BITS:FRAC_BITS];
            sf  = sat_sign(mag, neg_ff);
            if (sf[64] && (err_ff == ST_OK)) err_in = ST_OVER;
            res_in   = sf[63:0];
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (vcnt_ff >= CNT_W'(STACK_DEPTH)) begin
               if (err_ff == ST_OK) err_in = ST_OVER;
            end else begin
               v_we    = 1'b1;
               vcnt_in = vcnt_ff + 1'b1;
            end
            unique case (mode_ff)
               M_NUM_CHAR: state_in = S_DISPATCH;
               M_NUM_LAST: begin
                  mode_in  = M_DRAIN;
                  state_in = S_OP_READ;
               end
               default: state_in = S_OP_READ;
            endcase
         end
         S_OUT_RD: begin
            v_re     = (vcnt_ff != '0);
            state_in = S_OUT_CAP;
         end
         S_OUT_CAP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_value_in  = (vcnt_ff != '0) ? v_rd_ff : '0;
               out_status_in = ((vcnt_ff == '0) && (err_ff == ST_OK)) ? ST_UNDER : err_ff;
               rsp_valid_in  = 1'b1;
               vcnt_in       = '0;
               ocnt_in       = '0;
               acc_in        = '0;
               fd_in         = '0;
               nf_in         = '0;
               err_in        = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_vcnt_bound: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("value stack count beyond depth");

   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("operator stack count beyond depth");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && !req.last) |=> !$rose(rsp_valid_ff))
      else $error("response without final character");

   a_clean_after_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (vcnt_ff == '0 && ocnt_ff == '0 && err_ff == ST_OK))
      else $error("state not cleared at response");

   a_stop_in_num: assert property (@(posedge clock) disable iff (reset)
      nf_ff.stop |-> nf_ff.in_num)
      else $error("stopped run outside a number");

endmodule
`default_nettype wire

@@ tb/sv/tb_infix_expression_evaluator.sv @@
`default_nettype none
module tb_infix_expression_evaluator;
   import iee_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = STACK_DEPTH_DEF;
   localparam int FBITS       = FRAC_BITS_DEF;
   localparam int STALL_LIMIT = 40000;

   typedef struct {
      logic [63:0] value;
      status_type  status;
   } result_type;

   logic clock;
   logic reset;

   iee_req_if req_if();
   iee_rsp_if rsp_if();

   infix_expression_evaluator u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   result_type  expected_results[$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_left      = 0;
   int          quiet_cycles   = 0;
   int          sent_chars     = 0;

   logic [63:0] value_stk[DEPTH];
   op_code_type op_stk[DEPTH];
   int          value_cnt;
   int          op_cnt;
   logic [63:0] mantissa;
   int          frac_cnt;
   bit          in_num;
   bit          dot_seen;
   bit          run_stopped;
   status_type  first_error;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_eval();
      value_cnt   = 0;
      op_cnt      = 0;
      mantissa    = '0;
      frac_cnt    = 0;
      in_num      = 0;
      dot_seen    = 0;
      run_stopped = 0;
      first_error = ST_OK;
   endfunction

   function automatic void raise(status_type s);
      if (first_error == ST_OK) first_error = s;
   endfunction

   function automatic void push_value(logic [63:0] v);
      if (value_cnt >= DEPTH) begin
         raise(ST_OVER);
         return;
      end
      value_stk[value_cnt] = v;
      value_cnt++;
   endfunction

   function automatic logic [63:0] pop_value();
      if (value_cnt == 0) begin
         raise(ST_UNDER);
         return '0;
      end
      value_cnt--;
      return value_stk[value_cnt];
   endfunction

   function automatic void push_oper(op_code_type o);
      if (op_cnt >= DEPTH) begin
         raise(ST_OVER);
         return;
      end
      op_stk[op_cnt] = o;
      op_cnt++;
   endfunction

   function automatic int rank(op_code_type o);
      if (o == OP_ADD || o == OP_SUB) return 1;
      if (o == OP_MUL || o == OP_DIV) return 2;
      return 0;
   endfunction

   function automatic logic [63:0] abs64(logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [63:0] with_sign(logic [63:0] m, bit neg);
      if (neg) begin
         if (m > SMIN) begin
            raise(ST_OVER);
            return SMIN;
         end
         return ~m + 64'd1;
      end
      if (m > SMAX) begin
         raise(ST_OVER);
         return SMAX;
      end
      return m;
   endfunction

   function automatic logic [63:0] compute(logic [63:0] a, logic [63:0] b, op_code_type o);
      logic [63:0]  s;
      logic [127:0] w;
      case (o)
         OP_ADD: begin
            s = a + b;
            if (((a ^ s) & (b ^ s)) >> 63) begin
               raise(ST_OVER);
               return a[63] ? SMIN : SMAX;
            end
            return s;
         end
         OP_SUB: begin
            s = a - b;
            if (((a ^ b) & (a ^ s)) >> 63) begin
               raise(ST_OVER);
               return a[63] ? SMIN : SMAX;
            end
            return s;
         end
         OP_MUL: begin
            w = {64'd0, abs64(a)} * {64'd0, abs64(b)};
            s = (w[127:64+FBITS] != 0) ? '1 : w[63+FBITS:FBITS];
            return with_sign(s, a[63] ^ b[63]);
         end
         OP_DIV: begin
            if (b == 0) begin
               raise(ST_DIV0);
               return '0;
            end
            w = ({64'd0, abs64(a)} << FBITS) / {64'd0, abs64(b)};
            s = (w[127:64] != 0) ? '1 : w[63:0];
            return with_sign(s, a[63] ^ b[63]);
         end
         default: return '0;
      endcase
   endfunction

   function automatic void reduce_once();
      logic [63:0] b;
      logic [63:0] a;
      b = pop_value();
      a = pop_value();
      op_cnt--;
      push_value(compute(a, b, op_stk[op_cnt]));
   endfunction

   function automatic void close_number();
      logic [63:0]  p;
      logic [63:0]  ip;
      logic [127:0] rem;
      logic [127:0] f;
      logic [63:0]  v;
      p        = 64'd1;
      for (int i = 0; i < frac_cnt; i++) p = p * 64'd10;
      ip       = mantissa / p;
      rem      = {64'd0, mantissa % p};
      in_num   = 0;
      dot_seen = 0;
      run_stopped = 0;
      mantissa = '0;
      frac_cnt = 0;
      if (ip > (SMAX >> FBITS)) begin
         raise(ST_OVER);
         push_value(SMAX);
         return;
      end
      f   = (rem << FBITS) / {64'd0, p};
      rem = (rem << FBITS) % {64'd0, p};
      if ((rem << 1) >= {64'd0, p}) f = f + 1;
      v = (ip << FBITS) + f[63:0];
      if (v > SMAX) begin
         raise(ST_OVER);
         v = SMAX;
      end
      push_value(v);
   endfunction

   function automatic void number_char(logic [7:0] c);
      logic [63:0] d;
      bit          fits;
      if (!in_num) begin
         in_num   = 1;
         dot_seen = 0;
         run_stopped = 0;
         mantissa = '0;
         frac_cnt = 0;
      end
      if (run_stopped) return;
      if (c == CH_DOT) begin
         if (dot_seen) run_stopped = 1;
         else dot_seen = 1;
         return;
      end
      d    = 64'(c - CH_ZERO);
      fits = mantissa <= (64'(MANT_LIMIT) - d) / 64'd10;
      if (dot_seen) begin
         if (frac_cnt >= MAX_FRAC_DIGITS || !fits) return;
         mantissa = mantissa * 64'd10 + d;
         frac_cnt++;
      end else if (!fits) begin
         raise(ST_OVER);
         mantissa = 64'(MANT_LIMIT);
      end else begin
         mantissa = mantissa * 64'd10 + d;
      end
   endfunction

   function automatic bit evaluate_char(logic [7:0] c, logic l, output result_type r);
      op_code_type o;
      r.value  = '0;
      r.status = ST_OK;
      if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT) begin
         number_char(c);
      end else begin
         if (in_num) close_number();
         if (c == CH_LPAR) begin
            push_oper(OP_LPAR);
         end else if (c == CH_RPAR) begin
            while (op_cnt > 0 && op_stk[op_cnt-1] != OP_LPAR) reduce_once();
            if (op_cnt > 0) op_cnt--;
         end else if (c != CH_SPACE) begin
            case (c)
               CH_PLUS:  o = OP_ADD;
               CH_MINUS: o = OP_SUB;
               CH_STAR:  o = OP_MUL;
               CH_SLASH: o = OP_DIV;
               default:  o = OP_OTHER;
            endcase
            while (op_cnt > 0 && rank(op_stk[op_cnt-1]) >= rank(o)) reduce_once();
            push_oper(o);
         end
      end
      if (!l) return 0;
      if (in_num) close_number();
      while (op_cnt > 0) reduce_once();
      if (value_cnt > 0) r.value = value_stk[value_cnt-1];
      else raise(ST_UNDER);
      r.status = first_error;
      clear_eval();
      return 1;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
   endtask

   task automatic send_char(logic [7:0] c, logic l);
      result_type r;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= c;
      req_if.last      <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_chars++;
      if (evaluate_char(c, l, r)) expected_results.push_back(r);
   endtask

   task automatic send_text(logic [7:0] s[$]);
      foreach (s[i]) send_char(s[i], i == s.size() - 1);
   endtask

   task automatic send_string(string s);
      logic [7:0] q[$];
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      send_text(q);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic void add_number(ref logic [7:0] s[$]);
      int n;
      n = ($urandom_range(19) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) s.push_back(CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(2) == 0) begin
         s.push_back(CH_DOT);
         n = ($urandom_range(15) == 0) ? $urandom_range(10, 21) : $urandom_range(0, 4);
         for (int i = 0; i < n; i++) s.push_back(CH_ZERO + 8'($urandom_range(9)));
         if ($urandom_range(15) == 0) begin
            s.push_back(CH_DOT);
            s.push_back(CH_ZERO + 8'($urandom_range(9)));
         end
      end
   endfunction

   function automatic void add_expr(int depth, ref logic [7:0] s[$]);
      logic [7:0] ops[4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
      int n;
      n = $urandom_range(0, 3);
      for (int i = 0; i <= n; i++) begin
         if (i > 0) begin
            if ($urandom_range(3) == 0) s.push_back(CH_SPACE);
            s.push_back(ops[$urandom_range(3)]);
            if ($urandom_range(3) == 0) s.push_back(CH_SPACE);
         end
         if (depth > 0 && $urandom_range(3) == 0) begin
            s.push_back(CH_LPAR);
            add_expr(depth - 1, s);
            s.push_back(CH_RPAR);
         end else begin
            add_number(s);
         end
      end
   endfunction

   task automatic send_random(int items);
      logic [7:0] s[$];
      int         kind;
      int         stop_at;
      stop_at = sent_chars + items;
      while (sent_chars < stop_at) begin
         s    = {};
         kind = $urandom_range(99);
         if (kind < 10) begin
            repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(255)));
         end else begin
            add_expr(3, s);
            foreach (s[i]) if ($urandom_range(29) == 0) s[i] = 8'($urandom_range(255));
            if (kind < 18 && s.size() > 1) s = s[0:$urandom_range(s.size() - 2)];
         end
         send_text(s);
      end
   endtask

   task automatic test_directed();
      string nest;
      string many;
      send_string("1+2*3");
      send_string("(1+2)*3-4/2");
      send_string("7/0");
      send_string("1/3");
      send_string("-5");
      send_string("2..5.7 ");
      send_string("..");
      send_string("99999999999999999999");
      send_string("0.123456789012345678901");
      send_string("140737488355327.99999");
      send_string("140737488355328");
      send_string("0.00001");
      send_string("9999999999*9999999999");
      send_string("0-9999999999*9999999999-9999999999*9999999999");
      send_string("((4)");
      send_string("3)");
      send_string("()");
      send_string("+");
      send_string("3$4");
      send_string("9");
      send_string("1 2 3");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      nest = "";
      for (int i = 0; i < DEPTH + 2; i++) nest = {nest, "("};
      send_string({nest, "1"});
      many = "";
      for (int i = 0; i < DEPTH + 2; i++) many = {many, "1 "};
      send_string(many);
      drain_results();
   endtask

   task automatic test_no_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random(190);
      drain_results();
   endtask

   task automatic test_sender_idle();
      send_idle_pct  = 77;
      recv_stall_pct = 0;
      send_random(190);
      drain_results();
   endtask

   task automatic test_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 77;
      send_random(190);
      drain_results();
   endtask

   task automatic test_both_idle();
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      send_random(190);
      drain_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 3000;
      send_random(190);
      drain_results();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_if.value, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.value !== want.value)
               report_mismatch("value", rsp_if.value, want.value);
            if (rsp_if.status !== want.status)
               report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_code = '0;
      req_if.last      = 1'b0;
      rsp_if.ready     = 1'b0;
      clear_eval();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/iee_pkg.sv
hdl/iee_if.sv
hdl/infix_expression_evaluator.sv
tb/sv/tb_infix_expression_evaluator.sv
